// ===== hw/rtl/pgalloc_pkg.sv =====
package pgalloc_pkg;

  // Default sizing of the allocator.
  localparam int NUM_PAGES_DEF  = 32768;
  localparam int PAGE_BITS_DEF  = 12;
  localparam int COUNT_BITS_DEF = 8;

  // Fixed field widths.
  localparam int ADDR_W  = 32;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;
  localparam int CNTO_W  = 8;
  localparam int CFGI_W  = 2;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SHARE   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SEED    = 2'd3;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OOM     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BADADDR = 2'd2;
  localparam logic [STAT_W-1:0] STAT_COUNT   = 2'd3;

  // Configuration register indexes.
  localparam logic [CFGI_W-1:0] CFG_BASE = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_LOW  = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_TOP  = 2'd2;

  // Configuration reset values.
  localparam logic [ADDR_W-1:0] BASE_RST = 32'h8000_0000;
  localparam logic [ADDR_W-1:0] LOW_RST  = 32'h8002_0000;
  localparam logic [ADDR_W-1:0] TOP_RST  = 32'h8800_0000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;   // write zero to the count entry under the sweep counter
    logic accept;  // latch the item and launch the memory reads
    logic commit;  // write back, update the list and load the result
  } dp_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;  // the sweep is at the last entry
  } dp_stat_t;

endpackage

// ===== hw/rtl/pgalloc_ram.sv =====
module pgalloc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/pgalloc_ctrl.sv =====
module pgalloc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output pgalloc_pkg::dp_ctl_t  ctl,
  input  pgalloc_pkg::dp_stat_t stat
);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   rsp_valid_next;

  always_comb begin
    state_next = state;
    ctl        = '0;
    cmd_stall  = 1'b1;
    unique case (state)
      S_CLEAR: begin
        ctl.clear = 1'b1;
        if (stat.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd_stall  = 1'b0;
        ctl.accept = cmd_valid;
        if (cmd_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        // The result may only be loaded once the output register is free.
        ctl.commit = !rsp_valid || !rsp_stall;
        if (ctl.commit) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  assign rsp_valid_next = ctl.commit || (rsp_valid && rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

// ===== hw/rtl/pgalloc_dp.sv =====
module pgalloc_dp #(
  parameter int NUM_PAGES  = pgalloc_pkg::NUM_PAGES_DEF,
  parameter int PAGE_BITS  = pgalloc_pkg::PAGE_BITS_DEF,
  parameter int COUNT_BITS = pgalloc_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  pgalloc_pkg::dp_ctl_t              ctl,
  output pgalloc_pkg::dp_stat_t             stat,
  input  logic [pgalloc_pkg::CMD_W-1:0]     cmd,
  input  logic [pgalloc_pkg::ADDR_W-1:0]    page_addr,
  input  logic                              cfg_we,
  input  logic [pgalloc_pkg::CFGI_W-1:0]    cfg_index,
  input  logic [pgalloc_pkg::ADDR_W-1:0]    cfg_data,
  output logic [pgalloc_pkg::STAT_W-1:0]    status,
  output logic [pgalloc_pkg::ADDR_W-1:0]    result_addr,
  output logic                              page_freed,
  output logic [pgalloc_pkg::CNTO_W-1:0]    count_after
);

  localparam int IDX_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int AW    = pgalloc_pkg::ADDR_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  // Configuration registers.
  logic [AW-1:0] base_addr;
  logic [AW-1:0] low_addr;
  logic [AW-1:0] top_addr;

  // Free list control.
  logic [IDX_W-1:0] list_head;
  logic [IDX_W-1:0] list_head_next;
  logic [AW-1:0]    free_count;
  logic [AW-1:0]    free_count_next;
  logic             list_empty;

  // Clearing sweep.
  logic [IDX_W-1:0] clr_cnt;

  // Item registers.
  logic [pgalloc_pkg::CMD_W-1:0] cmd_q;
  logic [IDX_W-1:0]              idx_q;
  logic                          addr_ok_q;

  // Address check on the incoming item.
  logic [AW-1:0]    offset;
  logic [AW-1:0]    idx_wide;
  logic             addr_ok;
  logic [IDX_W-1:0] rd_idx;

  // Memory ports.
  logic [COUNT_BITS-1:0] cnt_rdata;
  logic [IDX_W-1:0]      link_rdata;
  logic                  cnt_we;
  logic [IDX_W-1:0]      cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic                  upd_we;
  logic [COUNT_BITS-1:0] upd_cnt;
  logic                  link_we;
  logic [IDX_W-1:0]      link_wdata;

  // Result of the command.
  logic [pgalloc_pkg::STAT_W-1:0] res_status;
  logic [AW-1:0]                  res_addr;
  logic                           res_freed;
  logic [COUNT_BITS-1:0]          res_cnt;
  logic [COUNT_BITS-1:0]          eff_cnt;
  logic [AW-1:0]                  res_cnt_wide;

  assign list_empty = (free_count == '0);

  assign offset   = page_addr - base_addr;
  assign idx_wide = offset >> PAGE_BITS;
  assign addr_ok  = (page_addr[PAGE_BITS-1:0] == '0) && (offset[PAGE_BITS-1:0] == '0) &&
                    (page_addr >= low_addr) && (page_addr < top_addr) &&
                    (idx_wide < AW'(NUM_PAGES));
  assign rd_idx   = (cmd == pgalloc_pkg::CMD_ALLOC) ? list_head : idx_wide[IDX_W-1:0];

  assign stat.clear_done = (clr_cnt == IDX_W'(NUM_PAGES - 1));

  always_comb begin
    res_status      = pgalloc_pkg::STAT_OK;
    res_addr        = '0;
    res_freed       = 1'b0;
    res_cnt         = '0;
    upd_we          = 1'b0;
    upd_cnt         = '0;
    link_we         = 1'b0;
    link_wdata      = list_empty ? '0 : list_head;
    list_head_next  = list_head;
    free_count_next = free_count;
    eff_cnt         = (cmd_q == pgalloc_pkg::CMD_SEED) ? COUNT_ONE : cnt_rdata;
    if (cmd_q == pgalloc_pkg::CMD_ALLOC) begin
      if (list_empty) begin
        res_status = pgalloc_pkg::STAT_OOM;
      end else begin
        // Pop the head; the list becomes empty when the last entry leaves.
        free_count_next = free_count - AW'(1);
        list_head_next  = (free_count == AW'(1)) ? '0 : link_rdata;
        upd_we          = 1'b1;
        upd_cnt         = COUNT_ONE;
        res_cnt         = COUNT_ONE;
        res_addr        = base_addr + (AW'(idx_q) << PAGE_BITS);
      end
    end else if (!addr_ok_q) begin
      res_status = pgalloc_pkg::STAT_BADADDR;
    end else if (cmd_q == pgalloc_pkg::CMD_SHARE) begin
      if (cnt_rdata == COUNT_MAX) begin
        res_status = pgalloc_pkg::STAT_COUNT;
        res_cnt    = COUNT_MAX;
      end else begin
        upd_we  = 1'b1;
        upd_cnt = cnt_rdata + COUNT_ONE;
        res_cnt = cnt_rdata + COUNT_ONE;
      end
    end else begin
      // Release, or seed which first forces the count to one.
      if (eff_cnt == '0) begin
        res_status = pgalloc_pkg::STAT_COUNT;
      end else begin
        upd_we  = 1'b1;
        upd_cnt = eff_cnt - COUNT_ONE;
        res_cnt = eff_cnt - COUNT_ONE;
        if (eff_cnt == COUNT_ONE) begin
          link_we         = 1'b1;
          list_head_next  = idx_q;
          free_count_next = (free_count == '1) ? free_count : free_count + AW'(1);
          res_freed       = 1'b1;
        end
      end
    end
  end

  assign res_cnt_wide = AW'(res_cnt);

  assign cnt_we    = ctl.clear || (ctl.commit && upd_we);
  assign cnt_waddr = ctl.clear ? clr_cnt : idx_q;
  assign cnt_wdata = ctl.clear ? '0 : upd_cnt;

  pgalloc_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_PAGES)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (ctl.accept),
    .raddr (rd_idx),
    .rdata (cnt_rdata)
  );

  pgalloc_ram #(
    .WIDTH (IDX_W),
    .DEPTH (NUM_PAGES)
  ) u_link_ram (
    .clk   (clk),
    .we    (ctl.commit && link_we),
    .waddr (idx_q),
    .wdata (link_wdata),
    .re    (ctl.accept),
    .raddr (rd_idx),
    .rdata (link_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      base_addr  <= pgalloc_pkg::BASE_RST;
      low_addr   <= pgalloc_pkg::LOW_RST;
      top_addr   <= pgalloc_pkg::TOP_RST;
      list_head  <= '0;
      free_count <= '0;
      clr_cnt    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          pgalloc_pkg::CFG_BASE: base_addr <= cfg_data;
          pgalloc_pkg::CFG_LOW:  low_addr  <= cfg_data;
          pgalloc_pkg::CFG_TOP:  top_addr  <= cfg_data;
          default: begin
          end
        endcase
      end
      if (ctl.clear) begin
        clr_cnt <= clr_cnt + IDX_W'(1);
      end
      if (ctl.commit) begin
        list_head  <= list_head_next;
        free_count <= free_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_q     <= cmd;
      idx_q     <= rd_idx;
      addr_ok_q <= addr_ok;
    end
    if (ctl.commit) begin
      status      <= res_status;
      result_addr <= res_addr;
      page_freed  <= res_freed;
      count_after <= res_cnt_wide[pgalloc_pkg::CNTO_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/page_allocator_refcount.sv =====
// Channel  | Direction | Handshake            | Payload
// cmd      | in        | cmd_valid, cmd_stall | cmd, page_addr
// rsp      | out       | rsp_valid, rsp_stall | status, result_addr, page_freed, count_after
// cfg      | in        | cfg_valid, cfg_ready | cfg_index, cfg_data
//
// Each item has an accept cycle, which checks the address and reads the count and link
// memories, and a write-back cycle, which writes them back and updates the free list head.
// After reset the count memory is cleared one entry a cycle, all NUM_PAGES entries, with
// cmd_stall held high; configuration writes are taken throughout.
// A stalled result waits in the output register; the item behind it is accepted but its
// write-back waits until the output register is free.
module page_allocator_refcount #(
  parameter int NUM_PAGES  = pgalloc_pkg::NUM_PAGES_DEF,
  parameter int PAGE_BITS  = pgalloc_pkg::PAGE_BITS_DEF,
  parameter int COUNT_BITS = pgalloc_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // Command channel.
  input  logic                           cmd_valid,
  output logic                           cmd_stall,
  input  logic [pgalloc_pkg::CMD_W-1:0]  cmd,
  input  logic [pgalloc_pkg::ADDR_W-1:0] page_addr,
  // Response channel.
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output logic [pgalloc_pkg::STAT_W-1:0] status,
  output logic [pgalloc_pkg::ADDR_W-1:0] result_addr,
  output logic                           page_freed,
  output logic [pgalloc_pkg::CNTO_W-1:0] count_after,
  // Configuration write channel.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pgalloc_pkg::CFGI_W-1:0] cfg_index,
  input  logic [pgalloc_pkg::ADDR_W-1:0] cfg_data
);

  // The controller sequences the clearing sweep, the accept cycle and the write-back cycle,
  // and owns the response valid flag. Everything else lives in the datapath.
  pgalloc_pkg::dp_ctl_t  ctl;
  pgalloc_pkg::dp_stat_t stat;

  // Configuration registers are plain flops, so a write is always taken at once.
  assign cfg_ready = 1'b1;

  pgalloc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .ctl       (ctl),
    .stat      (stat)
  );

  // The datapath holds the count and link memories, the list head, the free count used to
  // detect an empty list, and the output register.
  pgalloc_dp #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_BITS  (PAGE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .stat        (stat),
    .cmd         (cmd),
    .page_addr   (page_addr),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .status      (status),
    .result_addr (result_addr),
    .page_freed  (page_freed),
    .count_after (count_after)
  );

endmodule

// ===== tb/tb_page_allocator_refcount.sv =====
module tb_page_allocator_refcount;
  timeunit 1ns;
  timeprecision 1ps;

  // The testbench keeps its own copy of the allocator: the per-page reference
  // counts, the links of the free list, its head and the number of entries on
  // it. Every command item that the block accepts is run through this copy at
  // the edge where it is taken, and the outcome is queued. Every response item
  // that the block hands over is then checked, field by field, against the
  // oldest outcome in that queue.

  localparam int AW = pgalloc_pkg::ADDR_W;
  localparam int PG_BITS = pgalloc_pkg::PAGE_BITS_DEF;
  localparam int PAGES = pgalloc_pkg::NUM_PAGES_DEF;
  localparam int IDX_W = $clog2(PAGES);
  localparam int REF_W = pgalloc_pkg::COUNT_BITS_DEF;
  localparam int REF_MAX = (1 << REF_W) - 1;
  localparam int CNT_OUT_W = pgalloc_pkg::CNTO_W;
  localparam logic [AW-1:0] PG_SIZE = AW'(1) << PG_BITS;

  // The response side holds off twice for a long stretch once this many
  // response items have been taken. The command side keeps offering items
  // meanwhile, so the block fills up and must stall its input.
  localparam int HOLD_FIRST = 150;
  localparam int HOLD_SECOND = 450;
  localparam int HOLD_CYCLES = 64;

  // Each item is accepted, then written back, in the block. This pause is generous.
  localparam int SETTLE_CYCLES = 16;

  // Print no more than this many mismatch lines; all of them are counted.
  localparam int REPORT_LINES = 200;

  typedef struct packed {
    logic [pgalloc_pkg::CMD_W-1:0] op;
    logic [AW-1:0]                 pa;
  } page_cmd_t;

  typedef struct packed {
    logic [pgalloc_pkg::STAT_W-1:0] status;
    logic [AW-1:0]                  result_addr;
    logic                           page_freed;
    logic [CNT_OUT_W-1:0]           count_after;
  } page_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                           cmd_valid = 1'b0;
  logic                           cmd_stall;
  logic [pgalloc_pkg::CMD_W-1:0]  cmd = pgalloc_pkg::CMD_ALLOC;
  logic [AW-1:0]                  page_addr = '0;

  logic                           rsp_valid;
  logic                           rsp_stall = 1'b0;
  logic [pgalloc_pkg::STAT_W-1:0] status;
  logic [AW-1:0]                  result_addr;
  logic                           page_freed;
  logic [CNT_OUT_W-1:0]           count_after;

  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [pgalloc_pkg::CFGI_W-1:0] cfg_index = pgalloc_pkg::CFG_BASE;
  logic [AW-1:0]                  cfg_data = '0;

  page_allocator_refcount dut (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .page_addr  (page_addr),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .status     (status),
    .result_addr(result_addr),
    .page_freed (page_freed),
    .count_after(count_after),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Our copy of the configuration registers, starting at their reset values.
  logic [AW-1:0] cfg_base = pgalloc_pkg::BASE_RST;
  logic [AW-1:0] cfg_low = pgalloc_pkg::LOW_RST;
  logic [AW-1:0] cfg_top = pgalloc_pkg::TOP_RST;

  // Our copy of the allocator state.
  logic [REF_W-1:0] page_refs [PAGES];
  logic [IDX_W-1:0] free_link [PAGES];
  logic [IDX_W-1:0] free_head = '0;
  int unsigned      free_pages = 0;

  page_cmd_t    pending_cmds[$];
  page_result_t expected_results[$];

  int  mismatches = 0;
  int  results_taken = 0;
  int  cmd_gap = 0;
  int  rsp_wait = 0;
  int  hold_left = 0;
  int  holds_done = 0;
  bit  steady = 1'b0;

  task automatic report_mismatch(input string field, input logic [AW-1:0] got,
                                 input logic [AW-1:0] want);
    if (mismatches < REPORT_LINES)
      $display("%0t ns: %s is 0x%0h, expected 0x%0h", $time, field, got, want);
    mismatches++;
  endtask

  // Address of page index idx under the present base address.
  function automatic logic [AW-1:0] page_at(input int unsigned idx);
    return cfg_base + (AW'(idx) << PG_BITS);
  endfunction

  // Works out the response to one command and updates our copy of the state.
  function automatic page_result_t predict_page_op(
      input logic [pgalloc_pkg::CMD_W-1:0] op, input logic [AW-1:0] pa);
    page_result_t     r;
    logic [AW-1:0]    off;
    logic [IDX_W-1:0] idx;
    logic             addr_ok;
    r = '{pgalloc_pkg::STAT_OK, '0, 1'b0, '0};
    off = pa - cfg_base;
    // The address must be page aligned, lie in [low, top) and give an index
    // below the number of pages when taken relative to the base.
    addr_ok = (pa[PG_BITS-1:0] == '0) && (off[PG_BITS-1:0] == '0) &&
              (pa >= cfg_low) && (pa < cfg_top) && ((off >> PG_BITS) < PAGES);
    idx = IDX_W'(off >> PG_BITS);
    if (op == pgalloc_pkg::CMD_ALLOC) begin
      if (free_pages == 0) begin
        r.status = pgalloc_pkg::STAT_OOM;
      end else begin
        idx = free_head;
        free_pages--;
        free_head = (free_pages == 0) ? '0 : free_link[idx];
        page_refs[idx] = REF_W'(1);
        r.count_after = CNT_OUT_W'(1);
        r.result_addr = page_at(idx);
      end
    end else if (!addr_ok) begin
      r.status = pgalloc_pkg::STAT_BADADDR;
    end else if (op == pgalloc_pkg::CMD_SHARE) begin
      // A saturated count is flagged and left at its maximum.
      if (page_refs[idx] == REF_W'(REF_MAX)) begin
        r.status = pgalloc_pkg::STAT_COUNT;
        r.count_after = CNT_OUT_W'(REF_MAX);
      end else begin
        page_refs[idx] = page_refs[idx] + REF_W'(1);
        r.count_after = CNT_OUT_W'(page_refs[idx]);
      end
    end else begin
      // A seed is a release of a page whose count has just been set to one.
      if (op == pgalloc_pkg::CMD_SEED)
        page_refs[idx] = REF_W'(1);
      if (page_refs[idx] == '0) begin
        r.status = pgalloc_pkg::STAT_COUNT;
      end else begin
        page_refs[idx] = page_refs[idx] - REF_W'(1);
        r.count_after = CNT_OUT_W'(page_refs[idx]);
        if (page_refs[idx] == '0) begin
          // A page that is already free goes on the list a second time.
          free_link[idx] = (free_pages == 0) ? '0 : free_head;
          free_head = idx;
          if (free_pages != 32'hFFFF_FFFF)
            free_pages++;
          r.page_freed = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // Draws the idle cycles before the next item on either side. Now and then
  // the run switches to a stretch with no idling at all.
  function automatic int pick_gap();
    if ($urandom_range(0, 31) == 0)
      steady = !steady;
    return steady ? 0 : $urandom_range(0, 7);
  endfunction

  task automatic queue_op(input logic [pgalloc_pkg::CMD_W-1:0] op, input logic [AW-1:0] pa);
    pending_cmds.push_back(page_cmd_t'{op, pa});
  endtask

  // Random traffic. Most of it works on a small pool of pages so that counts
  // climb, pages go round the free list and the list runs dry; the rest is
  // aimed at the edges of the address check or is plain noise.
  task automatic queue_random_ops(input int n, input int unsigned pool_lo,
                                  input int unsigned pool_n);
    int unsigned                   pick;
    logic [pgalloc_pkg::CMD_W-1:0] op;
    logic [AW-1:0]                 pa;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      pa = page_at(pool_lo + $urandom_range(0, pool_n - 1));
      if (pick < 30) begin
        op = pgalloc_pkg::CMD_ALLOC;
        pa = $urandom;
      end else if (pick < 55) begin
        op = pgalloc_pkg::CMD_RELEASE;
      end else if (pick < 70) begin
        op = pgalloc_pkg::CMD_SHARE;
      end else if (pick < 82) begin
        op = pgalloc_pkg::CMD_SEED;
      end else begin
        case ($urandom_range(0, 2))
          0: op = pgalloc_pkg::CMD_RELEASE;
          1: op = pgalloc_pkg::CMD_SHARE;
          default: op = pgalloc_pkg::CMD_SEED;
        endcase
        case ($urandom_range(0, 5))
          0: pa = $urandom;
          1: pa = cfg_low - PG_SIZE;
          2: pa = cfg_top;
          3: pa = cfg_top - PG_SIZE;
          4: pa = cfg_low;
          default: pa = pa | AW'($urandom_range(1, PG_SIZE - 1));
        endcase
      end
      queue_op(op, pa);
    end
  endtask

  // Registers are only written with the block idle, so our copy can follow
  // at the edge where the write is taken.
  task automatic write_reg(input logic [pgalloc_pkg::CFGI_W-1:0] idx,
                           input logic [AW-1:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      pgalloc_pkg::CFG_BASE: cfg_base = val;
      pgalloc_pkg::CFG_LOW:  cfg_low = val;
      pgalloc_pkg::CFG_TOP:  cfg_top = val;
      default: ;
    endcase
  endtask

  task automatic set_window(input logic [AW-1:0] base, input logic [AW-1:0] low,
                            input logic [AW-1:0] top);
    write_reg(pgalloc_pkg::CFG_BASE, base);
    write_reg(pgalloc_pkg::CFG_LOW, low);
    write_reg(pgalloc_pkg::CFG_TOP, top);
  endtask

  // Waits until every command item has gone in and every response item has
  // come out, then lets the block settle.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_cmds.size() != 0 || cmd_valid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Command side. A new item is put up once the last one has been taken and
  // its idle cycles have passed; during a long hold-off on the response side
  // the idle cycles are skipped so that items keep pressing on the block.
  always @(posedge clk) begin : cmd_driver
    page_cmd_t nxt;
    if (rst) begin
      cmd_valid <= 1'b0;
      cmd_gap <= 0;
    end else if (!cmd_valid || !cmd_stall) begin
      if (cmd_gap > 0 && hold_left == 0) begin
        cmd_valid <= 1'b0;
        cmd_gap <= cmd_gap - 1;
      end else if (pending_cmds.size() != 0) begin
        nxt = pending_cmds.pop_front();
        cmd <= nxt.op;
        page_addr <= nxt.pa;
        cmd_valid <= 1'b1;
        cmd_gap <= pick_gap();
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // Response side. After each response item it stalls for a drawn number of
  // cycles; twice in the run it holds off for a long stretch instead.
  always @(posedge clk) begin : rsp_side
    int w;
    if (rst) begin
      rsp_stall <= 1'b0;
      rsp_wait <= 0;
      hold_left <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if ((holds_done == 0 && results_taken >= HOLD_FIRST) ||
                 (holds_done == 1 && results_taken >= HOLD_SECOND)) begin
      rsp_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end else if (rsp_valid && !rsp_stall) begin
      w = pick_gap();
      rsp_wait <= w;
      rsp_stall <= (w != 0);
    end else if (rsp_wait > 0) begin
      rsp_wait <= rsp_wait - 1;
      rsp_stall <= (rsp_wait > 1);
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // Checks each response item taken and predicts each command item taken.
  always @(posedge clk) begin : monitor
    page_result_t want;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        results_taken <= results_taken + 1;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected response, result_addr", result_addr, '0);
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status)
            report_mismatch("status", AW'(status), AW'(want.status));
          if (result_addr !== want.result_addr)
            report_mismatch("result_addr", result_addr, want.result_addr);
          if (page_freed !== want.page_freed)
            report_mismatch("page_freed", AW'(page_freed), AW'(want.page_freed));
          if (count_after !== want.count_after)
            report_mismatch("count_after", AW'(count_after), AW'(want.count_after));
        end
      end
      if (cmd_valid && !cmd_stall)
        expected_results.push_back(predict_page_op(cmd, page_addr));
    end
  end

  initial begin : stimulus
    foreach (page_refs[i]) begin
      page_refs[i] = '0;
      free_link[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset window: page 32 sits at the lowest address that may be released
    // and page 32767 is the last one below the top.
    queue_op(pgalloc_pkg::CMD_ALLOC, 32'hFFFF_FFFF);      // empty list, out of memory
    queue_op(pgalloc_pkg::CMD_RELEASE, page_at(40));      // release of a zero count
    queue_op(pgalloc_pkg::CMD_SHARE, page_at(40));
    queue_op(pgalloc_pkg::CMD_SHARE, page_at(40));
    queue_op(pgalloc_pkg::CMD_RELEASE, page_at(40));
    queue_op(pgalloc_pkg::CMD_RELEASE, page_at(40));      // count reaches zero, page freed
    queue_op(pgalloc_pkg::CMD_SEED, page_at(PAGES - 1));
    queue_op(pgalloc_pkg::CMD_SEED, cfg_low);
    queue_op(pgalloc_pkg::CMD_SEED, page_at(40));         // seeding a page already free
    queue_op(pgalloc_pkg::CMD_SHARE, page_at(40));        // sharing a free page ...
    queue_op(pgalloc_pkg::CMD_RELEASE, page_at(40));      // ... and freeing it once more
    queue_op(pgalloc_pkg::CMD_RELEASE, cfg_top);
    queue_op(pgalloc_pkg::CMD_SHARE, cfg_low - PG_SIZE);
    queue_op(pgalloc_pkg::CMD_SEED, page_at(40) | 32'h0000_0800);
    queue_op(pgalloc_pkg::CMD_RELEASE, 32'hFFFF_FFFF);
    queue_op(pgalloc_pkg::CMD_SHARE, 32'h0000_0000);
    // Drain the list, which holds page 40 three times, and run it dry.
    repeat (7) queue_op(pgalloc_pkg::CMD_ALLOC, $urandom);
    queue_random_ops(220, 36, 8);
    wait_drained();

    // A narrow window: pages 0 and 1 lie below the low address.
    set_window(32'h4000_0000, 32'h4000_2000, 32'h4002_0000);
    queue_random_ops(100, 0, 10);
    // Push one count into saturation and hold it there.
    repeat (REF_MAX + 5) queue_op(pgalloc_pkg::CMD_SHARE, page_at(5));
    repeat (3) queue_op(pgalloc_pkg::CMD_RELEASE, page_at(5));
    queue_random_ops(100, 0, 10);
    wait_drained();

    // Base near the top of the address space, so page 1 wraps to address
    // zero; the widest release range; an index one past the last page.
    set_window(32'hFFFF_F000, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_op(pgalloc_pkg::CMD_RELEASE, page_at(PAGES));
    queue_op(pgalloc_pkg::CMD_SEED, page_at(0));
    queue_op(pgalloc_pkg::CMD_SEED, page_at(1));
    queue_op(pgalloc_pkg::CMD_ALLOC, 32'h0000_0000);
    queue_op(pgalloc_pkg::CMD_ALLOC, 32'hFFFF_FFFF);
    queue_random_ops(120, 0, 8);
    wait_drained();

    // Low above top: nothing can pass the address check.
    set_window(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_random_ops(15, 0, 8);
    wait_drained();

    // An unaligned base: every page address fails, yet allocation still works
    // and reports addresses offset from that base.
    set_window(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_random_ops(30, 0, 8);
    wait_drained();

    // Back to the reset window, working at the top end of the page range.
    set_window(pgalloc_pkg::BASE_RST, pgalloc_pkg::LOW_RST, pgalloc_pkg::TOP_RST);
    queue_random_ops(80, PAGES - 6, 6);
    wait_drained();

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // The slowest correct run, with the clearing pass after reset and the
  // longest idling on both sides, needs about an eighth of this.
  initial begin : watchdog
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
